/* rtl/cpa_pkg.sv */
// Shared types, codes and mask helper for the CIDR prefix aggregator.
package cpa_pkg;

    localparam int unsigned ADDR_W   = 128;
    localparam int unsigned HALF_W   = 64;
    localparam int unsigned LEN_W    = 8;
    localparam int unsigned FAM_W    = 2;
    localparam int unsigned OC_W     = 2;
    localparam int unsigned V4_W     = 32;

    localparam logic [LEN_W-1:0] V4_MAX_LEN = LEN_W'(32);
    localparam logic [LEN_W-1:0] V6_MAX_LEN = LEN_W'(128);

    // family codes
    localparam logic [FAM_W-1:0] FAM_NULL = 2'd0;
    localparam logic [FAM_W-1:0] FAM_V4   = 2'd1;
    localparam logic [FAM_W-1:0] FAM_V6   = 2'd2;

    // outcome codes
    localparam logic [OC_W-1:0] OC_NONE     = 2'd0;
    localparam logic [OC_W-1:0] OC_A_HOLDS  = 2'd1;
    localparam logic [OC_W-1:0] OC_B_HOLDS  = 2'd2;
    localparam logic [OC_W-1:0] OC_MERGED   = 2'd3;

    typedef struct packed {
        logic [FAM_W-1:0]  family;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  length;
    } t_raw;

    typedef struct packed {
        logic              ok;
        logic [FAM_W-1:0]  family;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  length;
    } t_prefix;

    typedef struct packed {
        logic [OC_W-1:0]   outcome;
        logic [FAM_W-1:0]  family;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  length;
    } t_result;

    // Network mask: top len bits of the family's address space set.
    function automatic logic [ADDR_W-1:0] net_mask(logic [FAM_W-1:0] fam,
                                                   logic [LEN_W-1:0] len);
        logic [V4_W-1:0]   m4;
        logic [ADDR_W-1:0] m6;
        m4 = ~({V4_W{1'b1}} >> len);
        m6 = ~({ADDR_W{1'b1}} >> len);
        return (fam == FAM_V4) ? {{(ADDR_W-V4_W){1'b0}}, m4} : m6;
    endfunction

endpackage

/* rtl/cpa_prefix_norm.sv */
// Validates one prefix and clears its host bits.
module cpa_prefix_norm (
    input  cpa_pkg::t_raw    i_raw,
    output cpa_pkg::t_prefix o_pfx
);

    logic ok;

    always_comb begin
        ok = ((i_raw.family == cpa_pkg::FAM_V4) && (i_raw.length <= cpa_pkg::V4_MAX_LEN)) ||
             ((i_raw.family == cpa_pkg::FAM_V6) && (i_raw.length <= cpa_pkg::V6_MAX_LEN));
        o_pfx.ok     = ok;
        o_pfx.family = i_raw.family;
        o_pfx.length = i_raw.length;
        o_pfx.addr   = ok ? (i_raw.addr & cpa_pkg::net_mask(i_raw.family, i_raw.length))
                          : '0;
    end

endmodule

/* rtl/cpa_combine.sv */
// Decides containment or sibling merge for two normalized prefixes.
module cpa_combine (
    input  cpa_pkg::t_prefix i_a,
    input  cpa_pkg::t_prefix i_b,
    output cpa_pkg::t_result o_res
);

    logic                          usable;
    logic                          a_holds_b;
    logic                          b_holds_a;
    logic                          sibling;
    logic [cpa_pkg::LEN_W-1:0]     fam_width;
    logic [cpa_pkg::LEN_W-1:0]     host_bits;
    logic [cpa_pkg::ADDR_W-1:0]    last_bit;

    always_comb begin
        usable    = i_a.ok && i_b.ok && (i_a.family == i_b.family);
        a_holds_b = (i_b.length >= i_a.length) &&
                    ((i_b.addr & cpa_pkg::net_mask(i_a.family, i_a.length)) == i_a.addr);
        b_holds_a = (i_a.length >= i_b.length) &&
                    ((i_a.addr & cpa_pkg::net_mask(i_b.family, i_b.length)) == i_b.addr);
        fam_width = (i_a.family == cpa_pkg::FAM_V4) ? cpa_pkg::V4_MAX_LEN
                                                    : cpa_pkg::V6_MAX_LEN;
        // lowest network bit position; only meaningful for nonzero length
        host_bits = fam_width - i_a.length;
        last_bit  = {{(cpa_pkg::ADDR_W-1){1'b0}}, 1'b1} << host_bits;
        sibling   = (i_a.length == i_b.length) && (i_a.length != '0) &&
                    ((i_a.addr ^ i_b.addr) == last_bit);

        o_res.outcome = cpa_pkg::OC_NONE;
        o_res.family  = cpa_pkg::FAM_NULL;
        o_res.addr    = '0;
        o_res.length  = '0;
        priority if (!usable) begin
            o_res.outcome = cpa_pkg::OC_NONE;
        end else if (a_holds_b) begin
            o_res.outcome = cpa_pkg::OC_A_HOLDS;
            o_res.family  = i_a.family;
            o_res.addr    = i_a.addr;
            o_res.length  = i_a.length;
        end else if (b_holds_a) begin
            o_res.outcome = cpa_pkg::OC_B_HOLDS;
            o_res.family  = i_b.family;
            o_res.addr    = i_b.addr;
            o_res.length  = i_b.length;
        end else if (sibling) begin
            // a is masked to its length, so dropping the last bit re-masks it
            o_res.outcome = cpa_pkg::OC_MERGED;
            o_res.family  = i_a.family;
            o_res.addr    = i_a.addr & ~last_bit;
            o_res.length  = i_a.length - 1'b1;
        end else begin
            o_res.outcome = cpa_pkg::OC_NONE;
        end
    end

endmodule

/* rtl/cidr_prefix_aggregator.sv */
// Top level of the CIDR prefix aggregator: input register, combine logic, result register.
// Takes one pair of IP prefixes per beat and returns one aggregate per beat. Each beat
// is captured in an input register, validated, host-masked and combined in one pass of
// logic, and lands in a result register, which an output stall can hold back; throughput is
// one beat per cycle while the output is not stalled.
// When both registers hold a beat, an output stall stalls the input in the same cycle;
// otherwise the empty register takes one more beat first. Outcome 0 means the pair
// cannot be aggregated, and then all other result fields are zero; identical prefixes
// report outcome 1.
module cidr_prefix_aggregator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_a_family,
    input  logic [63:0] i_a_addr_hi,
    input  logic [63:0] i_a_addr_lo,
    input  logic [7:0]  i_a_length,
    input  logic [1:0]  i_b_family,
    input  logic [63:0] i_b_addr_hi,
    input  logic [63:0] i_b_addr_lo,
    input  logic [7:0]  i_b_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_outcome,
    output logic [1:0]  o_out_family,
    output logic [63:0] o_out_addr_hi,
    output logic [63:0] o_out_addr_lo,
    output logic [7:0]  o_out_length
);

    logic             r_in_valid;
    cpa_pkg::t_raw    r_a;
    cpa_pkg::t_raw    r_b;
    logic             r_out_valid;
    cpa_pkg::t_result r_res;

    cpa_pkg::t_prefix a_pfx;
    cpa_pkg::t_prefix b_pfx;
    cpa_pkg::t_result n_res;
    logic             out_ready;
    logic             in_ready;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign in_ready   = !r_in_valid || out_ready;
    assign o_in_stall = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && in_ready) begin
            r_a <= '{family: i_a_family, addr: {i_a_addr_hi, i_a_addr_lo}, length: i_a_length};
            r_b <= '{family: i_b_family, addr: {i_b_addr_hi, i_b_addr_lo}, length: i_b_length};
        end
        if (r_in_valid && out_ready) begin
            r_res <= n_res;
        end
    end

    cpa_prefix_norm u_norm_a (
        .i_raw (r_a),
        .o_pfx (a_pfx)
    );

    cpa_prefix_norm u_norm_b (
        .i_raw (r_b),
        .o_pfx (b_pfx)
    );

    cpa_combine u_combine (
        .i_a   (a_pfx),
        .i_b   (b_pfx),
        .o_res (n_res)
    );

    assign o_out_valid   = r_out_valid;
    assign o_outcome     = r_res.outcome;
    assign o_out_family  = r_res.family;
    assign o_out_addr_hi = r_res.addr[cpa_pkg::ADDR_W-1:cpa_pkg::HALF_W];
    assign o_out_addr_lo = r_res.addr[cpa_pkg::HALF_W-1:0];
    assign o_out_length  = r_res.length;

    // a held beat in the input register is never dropped while the input is stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && o_in_stall |=> r_in_valid)
        else $error("input register lost a stalled beat");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome == cpa_pkg::OC_NONE) |->
            (o_out_family == cpa_pkg::FAM_NULL) && (o_out_length == '0) &&
            (o_out_addr_hi == '0) && (o_out_addr_lo == '0))
        else $error("non-aggregatable result carries nonzero fields");

    a_len_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome != cpa_pkg::OC_NONE) |->
            ((o_out_family == cpa_pkg::FAM_V4) && (o_out_length <= cpa_pkg::V4_MAX_LEN)) ||
            ((o_out_family == cpa_pkg::FAM_V6) && (o_out_length <= cpa_pkg::V6_MAX_LEN)))
        else $error("aggregate has illegal family or length");

    a_v4_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_family == cpa_pkg::FAM_V4) |->
            (o_out_addr_hi == '0) && (o_out_addr_lo[63:32] == '0))
        else $error("IPv4 aggregate has upper address bits set");

endmodule
